// ===== hw/rtl/dzh_pkg.sv =====
// shared types and constants of the depth zero hold filter
package dzh_pkg;

  // configuration port widths
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_STALE_LIMIT = 8'd0;
  localparam cfg_idx_t REG_ZERO_GRACE  = 8'd1;

  // reset values of the registers
  localparam logic [31:0] STALE_LIMIT_RST = 32'd2000;
  localparam logic [31:0] ZERO_GRACE_RST  = 32'd1000;

  // configuration as seen by the back end
  typedef struct packed {
    logic [31:0] stale_limit_ms;
    logic [31:0] zero_grace_ms;
  } cfg_t;

endpackage

// ===== hw/rtl/dzh_if.sv =====
// item channels and configuration channel of the depth zero hold filter

// input items: timestamped events with an optional depth sample
interface dzh_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_ms;
  logic               has_sample;
  logic signed [16:0] sample_mm;

  modport source (output valid, now_ms, has_sample, sample_mm, input ready);
  modport sink   (input valid, now_ms, has_sample, sample_mm, output ready);
endinterface

// result items: one snapshot per input item
interface dzh_out_if;
  logic               valid;
  logic               ready;
  logic               publish_valid;
  logic               hold_active;
  logic               last_good_valid;
  logic [15:0]        good_depth_mm;
  logic [31:0]        good_age_ms;
  logic               raw_valid;
  logic signed [16:0] raw_mm;
  logic [31:0]        raw_age_ms;
  logic               zrun_active;
  logic [31:0]        zrun_age_ms;
  logic [31:0]        zero_frame_count;

  modport source (
    output valid, publish_valid, hold_active, last_good_valid,
           good_depth_mm, good_age_ms, raw_valid, raw_mm,
           raw_age_ms, zrun_active, zrun_age_ms, zero_frame_count,
    input  ready
  );
  modport sink (
    input  valid, publish_valid, hold_active, last_good_valid,
           good_depth_mm, good_age_ms, raw_valid, raw_mm,
           raw_age_ms, zrun_active, zrun_age_ms, zero_frame_count,
    output ready
  );
endinterface

// register writes
interface dzh_cfg_if
  import dzh_pkg::*;
;
  logic                valid;
  logic                ready;
  cfg_idx_t            index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/dzh_front.sv =====
// front end: accepts items, updates the filter state, queues a state record
module dzh_front #(
  parameter int unsigned DEPTH_BITS = 16,
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned REC_W      = 4 * TIME_BITS + DEPTH_BITS + 51
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  dzh_in_if.sink           in_i,
  output logic             push_o,
  output logic [REC_W-1:0] rec_o,
  input  logic             full_i
);

  localparam int unsigned CW = (DEPTH_BITS > 17) ? DEPTH_BITS : 17;
  localparam logic [CW-1:0] DEPTH_MAX = CW'({DEPTH_BITS{1'b1}});

  typedef struct packed {
    logic [TIME_BITS-1:0]  now;
    logic                  good_seen;
    logic [DEPTH_BITS-1:0] good_depth;
    logic [TIME_BITS-1:0]  good_time;
    logic                  raw_seen;
    logic signed [16:0]    raw_value;
    logic [TIME_BITS-1:0]  raw_time;
    logic [31:0]           zero_count;
    logic [TIME_BITS-1:0]  zero_start;
  } rec_t;

  logic                  good_seen_q, good_seen_d;
  logic [DEPTH_BITS-1:0] good_depth_q, good_depth_d;
  logic [TIME_BITS-1:0]  good_time_q, good_time_d;
  logic                  raw_seen_q, raw_seen_d;
  logic signed [16:0]    raw_value_q, raw_value_d;
  logic [TIME_BITS-1:0]  raw_time_q, raw_time_d;
  logic [31:0]           zero_count_q, zero_count_d;
  logic [TIME_BITS-1:0]  zero_start_q, zero_start_d;

  logic                  accept;
  logic [TIME_BITS-1:0]  now;
  logic [CW-1:0]         dist_ext;
  logic [DEPTH_BITS-1:0] dist_sat;
  rec_t                  rec;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign now        = TIME_BITS'(in_i.now_ms);

  // positive sample clipped to the depth range
  assign dist_ext = CW'(unsigned'(in_i.sample_mm[15:0]));
  assign dist_sat = (dist_ext > DEPTH_MAX) ? DEPTH_MAX[DEPTH_BITS-1:0]
                                           : dist_ext[DEPTH_BITS-1:0];

  // state update for one item
  always_comb begin
    good_seen_d  = good_seen_q;
    good_depth_d = good_depth_q;
    good_time_d  = good_time_q;
    raw_seen_d   = raw_seen_q;
    raw_value_d  = raw_value_q;
    raw_time_d   = raw_time_q;
    zero_count_d = zero_count_q;
    zero_start_d = zero_start_q;
    if (in_i.has_sample) begin
      raw_value_d = in_i.sample_mm;
      raw_time_d  = now;
      raw_seen_d  = 1'b1;
      if (in_i.sample_mm > 17'sd0) begin
        good_depth_d = dist_sat;
        good_time_d  = now;
        good_seen_d  = 1'b1;
        zero_count_d = '0;
        zero_start_d = '0;
      end else if (in_i.sample_mm == 17'sd0) begin
        if (zero_count_q == '0) begin
          zero_start_d = now;
        end
        zero_count_d = zero_count_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_seen_q  <= 1'b0;
      good_depth_q <= '0;
      good_time_q  <= '0;
      raw_seen_q   <= 1'b0;
      raw_value_q  <= -17'sd1;
      raw_time_q   <= '0;
      zero_count_q <= '0;
      zero_start_q <= '0;
    end else if (accept) begin
      good_seen_q  <= good_seen_d;
      good_depth_q <= good_depth_d;
      good_time_q  <= good_time_d;
      raw_seen_q   <= raw_seen_d;
      raw_value_q  <= raw_value_d;
      raw_time_q   <= raw_time_d;
      zero_count_q <= zero_count_d;
      zero_start_q <= zero_start_d;
    end
  end

  // record of the state after this item
  always_comb begin
    rec.now        = now;
    rec.good_seen  = good_seen_d;
    rec.good_depth = good_depth_d;
    rec.good_time  = good_time_d;
    rec.raw_seen   = raw_seen_d;
    rec.raw_value  = raw_value_d;
    rec.raw_time   = raw_time_d;
    rec.zero_count = zero_count_d;
    rec.zero_start = zero_start_d;
  end

  assign push_o = accept;
  assign rec_o  = rec;

endmodule

// ===== hw/rtl/dzh_fifo.sv =====
// two entry queue between front end and back end
module dzh_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/dzh_back.sv =====
// back end: ages and publish decision, registered result item
module dzh_back
  import dzh_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = 16,
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned REC_W      = 4 * TIME_BITS + DEPTH_BITS + 51
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic [REC_W-1:0] rec_i,
  input  logic             empty_i,
  output logic             pop_o,
  dzh_out_if.source        out_o
);

  localparam int unsigned AW = (TIME_BITS > 32) ? TIME_BITS : 32;

  typedef struct packed {
    logic [TIME_BITS-1:0]  now;
    logic                  good_seen;
    logic [DEPTH_BITS-1:0] good_depth;
    logic [TIME_BITS-1:0]  good_time;
    logic                  raw_seen;
    logic signed [16:0]    raw_value;
    logic [TIME_BITS-1:0]  raw_time;
    logic [31:0]           zero_count;
    logic [TIME_BITS-1:0]  zero_start;
  } rec_t;

  rec_t                 rec;
  logic                 zactive;
  logic [TIME_BITS-1:0] good_age, raw_age, zero_age;
  logic                 fresh, in_grace, publish, holding;
  logic                 valid_q;

  assign rec = rec_i;

  // ages modulo the time width, zero where the stamp is not valid
  assign zactive  = rec.zero_count != '0;
  assign good_age = rec.good_seen ? rec.now - rec.good_time : '0;
  assign raw_age  = rec.raw_seen ? rec.now - rec.raw_time : '0;
  assign zero_age = zactive ? rec.now - rec.zero_start : '0;

  // publish decision
  assign fresh    = AW'(good_age) <= AW'(cfg_i.stale_limit_ms);
  assign in_grace = AW'(zero_age) <= AW'(cfg_i.zero_grace_ms);
  assign publish  = rec.good_seen && fresh && (!zactive || in_grace);
  assign holding  = rec.good_seen && fresh && zactive && in_grace;

  // output register takes a new item when empty or being drained
  assign pop_o       = !empty_i && (!valid_q || out_o.ready);
  assign out_o.valid = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_o.ready) begin
      valid_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_o.publish_valid    <= publish;
      out_o.hold_active      <= holding;
      out_o.last_good_valid  <= rec.good_seen;
      out_o.good_depth_mm    <= rec.good_seen ? 16'(rec.good_depth) : 16'd0;
      out_o.good_age_ms      <= 32'(good_age);
      out_o.raw_valid        <= rec.raw_seen && !rec.raw_value[16];
      out_o.raw_mm           <= rec.raw_value;
      out_o.raw_age_ms       <= 32'(raw_age);
      out_o.zrun_active      <= zactive;
      out_o.zrun_age_ms      <= 32'(zero_age);
      out_o.zero_frame_count <= rec.zero_count;
    end
  end

endmodule

// ===== hw/rtl/depth_zero_hold_filter.sv =====
// top level of the depth zero hold filter
//
//   channel  dir  handshake       payload
//   in_i     in   valid / ready   now_ms, has_sample, sample_mm
//   out_o    out  valid / ready   snapshot of filter state, one per input item
//   cfg_i    in   valid / ready   index, data (0 stale limit, 1 zero grace)
//
// one item per cycle sustained while out_o is ready
// the front end updates state in the accept cycle, the back end computes ages
// and the publish decision on the way into the output register
// a two entry queue parts the sides; input ready drops only when it is full
// reset clears state and loads the register defaults; cfg ready is always high
module depth_zero_hold_filter
  import dzh_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = 16,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dzh_in_if.sink    in_i,
  dzh_out_if.source out_o,
  dzh_cfg_if.sink   cfg_i
);

  localparam int unsigned REC_W = 4 * TIME_BITS + DEPTH_BITS + 51;

  cfg_t             cfg_q;
  logic             push, pop, full, empty;
  logic [REC_W-1:0] wrec, rrec;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stale_limit_ms <= STALE_LIMIT_RST;
      cfg_q.zero_grace_ms  <= ZERO_GRACE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_STALE_LIMIT: cfg_q.stale_limit_ms <= cfg_i.data;
        REG_ZERO_GRACE:  cfg_q.zero_grace_ms  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  dzh_front #(
    .DEPTH_BITS(DEPTH_BITS),
    .TIME_BITS (TIME_BITS),
    .REC_W     (REC_W)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .push_o(push),
    .rec_o (wrec),
    .full_i(full)
  );

  dzh_fifo #(
    .WIDTH(REC_W)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(wrec),
    .full_o (full),
    .pop_i  (pop),
    .rdata_o(rrec),
    .empty_o(empty)
  );

  dzh_back #(
    .DEPTH_BITS(DEPTH_BITS),
    .TIME_BITS (TIME_BITS),
    .REC_W     (REC_W)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .rec_i  (rrec),
    .empty_i(empty),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

// ===== verif/depth_zero_hold_filter_tb.sv =====
// self-checking testbench of the depth zero hold filter
module depth_zero_hold_filter_tb;
  import dzh_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES    = 6;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned ITEMS_PER_PHASE = 265;
  localparam int unsigned NUM_PHASES      = 7;

  // indexes outside the register file, writes to them are dropped
  localparam cfg_idx_t REG_UNUSED = 8'd2;
  localparam cfg_idx_t REG_TOP    = 8'hFF;

  // one filter snapshot
  typedef struct {
    logic               publish_valid;
    logic               hold_active;
    logic               last_good_valid;
    logic [15:0]        good_depth_mm;
    logic [31:0]        good_age_ms;
    logic               raw_valid;
    logic signed [16:0] raw_mm;
    logic [31:0]        raw_age_ms;
    logic               zrun_active;
    logic [31:0]        zrun_age_ms;
    logic [31:0]        zero_frame_count;
  } snapshot_t;

  // depth filter predictor and queue of expected snapshots
  class depth_snapshot_board;
    logic [31:0]        stale_limit;
    logic [31:0]        zero_grace;
    logic [15:0]        good_depth;
    logic [31:0]        good_time;
    bit                 good_seen;
    logic signed [16:0] raw_value;
    logic [31:0]        raw_time;
    bit                 raw_seen;
    logic [31:0]        zero_count;
    logic [31:0]        zero_start;
    snapshot_t          snapshot_q[$];
    int unsigned        errors;
    int unsigned        items;
    int unsigned        results;
    int unsigned        published;
    int unsigned        held;

    function new();
      stale_limit = STALE_LIMIT_RST;
      zero_grace  = ZERO_GRACE_RST;
      good_depth  = '0;
      good_time   = '0;
      good_seen   = 1'b0;
      raw_value   = -17'sd1;
      raw_time    = '0;
      raw_seen    = 1'b0;
      zero_count  = '0;
      zero_start  = '0;
      errors      = 0;
      items       = 0;
      results     = 0;
      published   = 0;
      held        = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [31:0] data);
      if (idx == REG_STALE_LIMIT) begin
        stale_limit = data;
      end else if (idx == REG_ZERO_GRACE) begin
        zero_grace = data;
      end
    endfunction

    function int unsigned pending();
      return snapshot_q.size();
    endfunction

    // update the filter state with one item and queue its snapshot
    function void note_input(logic [31:0] now, logic has, logic signed [16:0] smp);
      snapshot_t   s;
      logic        zact;
      logic [31:0] good_age;
      logic [31:0] zero_age;
      items++;
      if (has) begin
        raw_value = smp;
        raw_time  = now;
        raw_seen  = 1'b1;
        if (smp > 17'sd0) begin
          // a positive 17 bit sample always fits the 16 bit depth
          good_depth = smp[15:0];
          good_time  = now;
          good_seen  = 1'b1;
          zero_count = '0;
          zero_start = '0;
        end else if (smp == 17'sd0) begin
          if (zero_count == 32'd0) begin
            zero_start = now;
          end
          zero_count = zero_count + 32'd1;
        end
      end
      zact     = (zero_count != 32'd0);
      zero_age = zact ? now - zero_start : 32'd0;
      good_age = good_seen ? now - good_time : 32'd0;
      s.publish_valid    = good_seen && (good_age <= stale_limit) &&
                           (!zact || (zero_age <= zero_grace));
      s.hold_active      = s.publish_valid && zact;
      s.last_good_valid  = good_seen;
      s.good_depth_mm    = good_seen ? good_depth : 16'd0;
      s.good_age_ms      = good_age;
      s.raw_valid        = raw_seen && !raw_value[16];
      s.raw_mm           = raw_value;
      s.raw_age_ms       = raw_seen ? now - raw_time : 32'd0;
      s.zrun_active      = zact;
      s.zrun_age_ms      = zero_age;
      s.zero_frame_count = zact ? zero_count : 32'd0;
      snapshot_q.push_back(s);
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected %h, got %h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    // compare one snapshot from the block with the oldest expectation
    function void check_result(snapshot_t got);
      snapshot_t exp;
      if (snapshot_q.size() == 0) begin
        $error("snapshot arrived with no item pending");
        errors++;
        return;
      end
      exp = snapshot_q.pop_front();
      results++;
      if (got.publish_valid === 1'b1) published++;
      if (got.hold_active === 1'b1) held++;
      compare("publish_valid", exp.publish_valid, got.publish_valid);
      compare("hold_active", exp.hold_active, got.hold_active);
      compare("last_good_valid", exp.last_good_valid, got.last_good_valid);
      compare("good_depth_mm", exp.good_depth_mm, got.good_depth_mm);
      compare("good_age_ms", exp.good_age_ms, got.good_age_ms);
      compare("raw_valid", exp.raw_valid, got.raw_valid);
      compare("raw_mm", exp.raw_mm, got.raw_mm);
      compare("raw_age_ms", exp.raw_age_ms, got.raw_age_ms);
      compare("zrun_active", exp.zrun_active, got.zrun_active);
      compare("zrun_age_ms", exp.zrun_age_ms, got.zrun_age_ms);
      compare("zero_frame_count", exp.zero_frame_count, got.zero_frame_count);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   hold_req = 1'b0;
  bit   steady   = 1'b0;

  depth_snapshot_board sb;

  dzh_in_if  in_if ();
  dzh_out_if out_if ();
  dzh_cfg_if cfg_if ();

  depth_zero_hold_filter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // gap length, mostly short and a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // next timestamp: mostly small steps, sometimes jumps and wraps
  function automatic logic [31:0] advance_time(logic [31:0] now);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return now + $urandom_range(0, 15);
    if (r < 85) return now + $urandom_range(0, 300);
    if (r < 95) return now + $urandom_range(0, 3000);
    if (r < 98) return $urandom();
    return 32'hFFFF_FFF0 + $urandom_range(0, 15);
  endfunction

  function automatic logic signed [16:0] rand_positive();
    if ($urandom_range(0, 1) == 0) return 17'($urandom_range(1, 255));
    return 17'($urandom_range(1, 65535));
  endfunction

  function automatic logic signed [16:0] rand_negative();
    int v;
    if ($urandom_range(0, 9) < 7) return -17'sd1;
    v = -int'($urandom_range(1, 65536));
    return v[16:0];
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned n;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        repeat (HOLD_OFF_CYCLES) begin
          @(negedge clk_i);
          out_if.ready = 1'b0;
        end
        hold_req = 1'b0;
      end else begin
        n = steady ? 16 : $urandom_range(1, 12);
        repeat (n) begin
          @(negedge clk_i);
          out_if.ready = 1'b1;
        end
        if (!steady) begin
          n = pick_gap();
          repeat (n) begin
            @(negedge clk_i);
            out_if.ready = 1'b0;
          end
        end
      end
    end
  end

  // monitor: note accepted items and check accepted snapshots
  always @(posedge clk_i) begin
    snapshot_t got;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_input(in_if.now_ms, in_if.has_sample, in_if.sample_mm);
      end
      if (out_if.valid && out_if.ready) begin
        got.publish_valid    = out_if.publish_valid;
        got.hold_active      = out_if.hold_active;
        got.last_good_valid  = out_if.last_good_valid;
        got.good_depth_mm    = out_if.good_depth_mm;
        got.good_age_ms      = out_if.good_age_ms;
        got.raw_valid        = out_if.raw_valid;
        got.raw_mm           = out_if.raw_mm;
        got.raw_age_ms       = out_if.raw_age_ms;
        got.zrun_active      = out_if.zrun_active;
        got.zrun_age_ms      = out_if.zrun_age_ms;
        got.zero_frame_count = out_if.zero_frame_count;
        sb.check_result(got);
      end
    end
  end

  // watchdog on cycles without any accepted item, snapshot or register write
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("** depth_zero_hold_filter: FAILED **");
    $finish;
  end

  // offer one item and wait for it to be taken
  task automatic send_item(logic [31:0] now, logic has, logic signed [16:0] smp);
    @(negedge clk_i);
    in_if.valid      = 1'b1;
    in_if.now_ms     = now;
    in_if.has_sample = has;
    in_if.sample_mm  = smp;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
  endtask

  task automatic sender_gap(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
    end
  endtask

  task automatic drive(logic [31:0] now, logic has, logic signed [16:0] smp);
    send_item(now, has, smp);
    if (!steady) sender_gap(pick_gap());
  endtask

  // wait until every snapshot is back and the pipeline is empty
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    sb.set_register(idx, data);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // stimulus
  initial begin
    logic [31:0]        stale_tab [NUM_PHASES];
    logic [31:0]        grace_tab [NUM_PHASES];
    logic [31:0]        now;
    logic               has;
    logic signed [16:0] smp;
    int unsigned        zeros_left;
    int unsigned        r;

    sb = new();
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.now_ms      = '0;
    in_if.has_sample  = 1'b0;
    in_if.sample_mm   = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_STALE_LIMIT;
    cfg_if.data       = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part under the reset register values
    drive(32'd0, 1'b0, 17'sd0);            // query before any sample
    drive(32'd5, 1'b1, -17'sd1);           // invalid sample
    drive(32'd6, 1'b1, -17'sd65536);       // most negative sample
    drive(32'd10, 1'b1, 17'sd0);           // zero run with no good depth
    drive(32'd20, 1'b1, 17'sd0);
    drive(32'd30, 1'b1, 17'sd65535);       // largest depth ends the run
    drive(32'd40, 1'b1, 17'sd1);
    drive(32'd500, 1'b1, 17'sd0);          // zero run held
    drive(32'd1500, 1'b0, 17'sd123);       // run age at grace limit
    drive(32'd1501, 1'b0, -17'sd7);        // run age past grace
    drive(32'd1501, 1'b1, 17'sd0);
    drive(32'd2040, 1'b1, 17'sd100);
    drive(32'd4040, 1'b0, 17'sd0);         // good age at stale limit
    drive(32'd4041, 1'b0, 17'sd0);         // good age past stale limit
    drive(32'd4041, 1'b1, -17'sd5);        // negative only touches raw
    drive(32'hFFFF_FFF0, 1'b1, 17'sd77);   // ages across the time wrap
    drive(32'h0000_0010, 1'b0, 17'sd0);
    drive(32'h0000_0010, 1'b1, 17'sd0);
    drive(32'hFFFF_FFFF, 1'b0, 17'sd0);    // time running backward
    drive(32'd0, 1'b1, 17'sd200);          // good stamp at time zero
    drive(32'd0, 1'b0, 17'sd0);
    drive(32'hFFFF_FFFF, 1'b1, 17'sd65535);
    drive(32'hFFFF_FFFF, 1'b1, 17'sd0);

    stale_tab[0] = 32'd0;          grace_tab[0] = 32'd0;
    stale_tab[1] = 32'hFFFF_FFFF;  grace_tab[1] = 32'hFFFF_FFFF;
    stale_tab[2] = 32'd50;         grace_tab[2] = 32'd20;
    stale_tab[3] = 32'd300;        grace_tab[3] = 32'd5;
    stale_tab[4] = 32'd20;         grace_tab[4] = 32'd300;
    stale_tab[5] = STALE_LIMIT_RST; grace_tab[5] = ZERO_GRACE_RST;
    stale_tab[6] = $urandom_range(0, 500);
    grace_tab[6] = $urandom_range(0, 500);

    now        = 32'd1000;
    zeros_left = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      cfg_write(REG_STALE_LIMIT, stale_tab[p]);
      cfg_write(REG_ZERO_GRACE, grace_tab[p]);
      if (p == 3) begin
        // writes to unknown indexes must leave the registers alone
        cfg_write(REG_UNUSED, $urandom());
        cfg_write(REG_TOP, $urandom());
      end
      steady = (p == 4);

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        now = advance_time(now);
        if (zeros_left > 0) begin
          // inside a zero burst, with a few queries mixed in
          zeros_left--;
          has = ($urandom_range(0, 4) != 0);
          smp = has ? 17'sd0 : 17'($urandom());
        end else begin
          r = $urandom_range(0, 99);
          if (r < 25) begin
            zeros_left = $urandom_range(1, 15);
            has = 1'b1;
            smp = 17'sd0;
          end else if (r < 60) begin
            has = 1'b1;
            smp = rand_positive();
          end else if (r < 75) begin
            has = 1'b0;
            smp = 17'($urandom());
          end else if (r < 90) begin
            has = 1'b1;
            smp = rand_negative();
          end else begin
            has = 1'b1;
            smp = 17'sd0;
          end
        end
        send_item(now, has, smp);
        // long receiver hold-off while items keep coming
        if (p == 1 && i == 100) hold_req = 1'b1;
        if (p == 2 && i == 150) begin
          wait_drained();
        end else if (!steady && !hold_req) begin
          sender_gap(pick_gap());
        end
      end
    end

    wait_drained();
    $display("covered %0d items and %0d snapshots over %0d register settings",
             sb.items, sb.results, NUM_PHASES + 1);
    $display("snapshots published %0d, held through zero runs %0d",
             sb.published, sb.held);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** depth_zero_hold_filter: PASSED **");
    end else begin
      $display("** depth_zero_hold_filter: FAILED **");
    end
    $finish;
  end

endmodule
